@@ rtl/rcps_pkg.sv @@
// Shared types and constants for the raycast column pixel shader.
package rcps_pkg;

    // Saturation limits for the screen and texture height registers
    localparam int unsigned MAX_SCREEN  = 2048;
    localparam int unsigned MAX_TEXTURE = 1024;

    // Field widths
    localparam int unsigned COL_W    = 11;
    localparam int unsigned ROW_W    = 11;
    localparam int unsigned END_W    = 12;
    localparam int unsigned LH_W     = 16;
    localparam int unsigned TEX_W    = 10;
    localparam int unsigned PITCH_W  = 15;
    localparam int unsigned BPP_W    = 4;
    localparam int unsigned SCR_W    = 12;
    localparam int unsigned TEXH_W   = 11;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned ADDR_W   = 25;
    localparam int unsigned FULL_W   = 27;   // unclipped address and bound
    localparam int unsigned ROWP_W   = ROW_W + PITCH_W;
    localparam int unsigned COLP_W   = COL_W + BPP_W;
    localparam int unsigned N0_W     = 17;   // signed row offset
    localparam int unsigned NPROD_W  = 29;   // signed offset * texture height
    localparam int unsigned MAG_W    = 26;   // magnitude of the dividend
    localparam int unsigned DIV_STEPS = MAG_W;

    // Stream widths
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 72;
    localparam int unsigned M_USER_W = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        REGION_CEILING = 2'd0,
        REGION_WALL    = 2'd1,
        REGION_FLOOR   = 2'd2
    } region_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_PITCH     = 3'd0,
        CFG_BYTES_PER_PIX = 3'd1,
        CFG_SCREEN_HEIGHT = 3'd2,
        CFG_TEX_HEIGHT    = 3'd3,
        CFG_CEILING_COLOR = 3'd4,
        CFG_FLOOR_COLOR   = 3'd5
    } cfg_index_t;

endpackage

@@ rtl/raycast_column_pixel_shader.sv @@
// Top level: pipelined raycaster column pixel classifier with texture row divider.
//
// Usage:
//   s_* is the input pixel stream (one beat per screen pixel), m_* the result
//   stream (one beat per input beat, same order). The cfg_* write channel sets
//   pitch, pixel size, screen and texture height and the two fill colors; it
//   is always ready and must only be written while no beat is in flight.
// Stages: classify and products, address sum and texture multiply, sign
//   split and bound compare, 26 restoring-divider steps (one quotient bit
//   each), sign fix-up into the output register.
// Throughput: one beat per cycle while the skid is empty, set by the
//   one-bit-per-stage divider chain.
// Stall: a one-beat skid buffer sits behind the output register; s_tready is
//   low only while the skid holds a beat, and then every stage holds, so
//   nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads the
//   register defaults (pitch 4096, 4 bytes/pixel, 720 rows, 64 texture rows,
//   black fill colors).
module raycast_column_pixel_shader
    import rcps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // column[10:0], row[21:11], span_start[32:22], span_end[44:33],
    // wall_height[60:45], texture_column[70:61], zero pad[71]
    input  logic [S_DATA_W-1:0]    s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // byte_address[24:0], write_ok[25], fill_color[49:26], texel_x[59:50],
    // texel_y[69:60], zero pad[71:70]
    output logic [M_DATA_W-1:0]    m_tdata,
    // region[1:0]
    output logic [M_USER_W-1:0]    m_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Stage types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                     valid;
        region_t                  region;
        logic                     ok_fill;     // row < screen height
        logic [ROWP_W-1:0]        row_prod;
        logic [COLP_W-1:0]        col_prod;
        logic signed [N0_W-1:0]   n0;
        logic [LH_W-1:0]          divisor;
        logic                     zflag;       // zero wall or texture height
        logic [TEX_W-1:0]         tex_col;
    } s1_stage_t;

    typedef struct packed {
        logic                       valid;
        region_t                    region;
        logic                       ok_fill;
        logic [FULL_W-1:0]          addr;
        logic signed [NPROD_W-1:0]  nprod;
        logic [LH_W-1:0]            divisor;
        logic                       zflag;
        logic [TEX_W-1:0]           tex_col;
    } s2_stage_t;

    typedef struct packed {
        logic               valid;
        region_t            region;
        logic               ok;
        logic [ADDR_W-1:0]  addr;
        logic               neg;
        logic               zflag;
        logic [TEX_W-1:0]   tex_col;
        logic [LH_W-1:0]    divisor;
        logic [LH_W-1:0]    rem;
        logic [MAG_W-1:0]   dq;          // dividend bits out, quotient bits in
    } div_stage_t;

    typedef struct packed {
        region_t            region;
        logic [ADDR_W-1:0]  addr;
        logic               ok;
        logic [COLOR_W-1:0] fill;
        logic [TEX_W-1:0]   texel_x;
        logic [TEX_W-1:0]   texel_y;
    } out_beat_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PITCH_W-1:0] pitch_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [SCR_W-1:0]   scr_h_reg;
    logic [TEXH_W-1:0]  tex_h_reg;
    logic [COLOR_W-1:0] ceil_color_reg;
    logic [COLOR_W-1:0] floor_color_reg;
    logic [FULL_W-1:0]  bound_reg;       // pitch * screen height

    logic [SCR_W-1:0]   scr_h_sat;
    logic [TEXH_W-1:0]  tex_h_sat;

    assign cfg_ready = 1'b1;

    always_comb begin
        scr_h_sat = (cfg_data[SCR_W-1:0] > SCR_W'(MAX_SCREEN))
                    ? SCR_W'(MAX_SCREEN) : cfg_data[SCR_W-1:0];
        tex_h_sat = (cfg_data[TEXH_W-1:0] > TEXH_W'(MAX_TEXTURE))
                    ? TEXH_W'(MAX_TEXTURE) : cfg_data[TEXH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg       <= PITCH_W'(4096);
            bpp_reg         <= BPP_W'(4);
            scr_h_reg       <= SCR_W'(720);
            tex_h_reg       <= TEXH_W'(64);
            ceil_color_reg  <= '0;
            floor_color_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROW_PITCH:     pitch_reg       <= cfg_data[PITCH_W-1:0];
                CFG_BYTES_PER_PIX: bpp_reg         <= cfg_data[BPP_W-1:0];
                CFG_SCREEN_HEIGHT: scr_h_reg       <= scr_h_sat;
                CFG_TEX_HEIGHT:    tex_h_reg       <= tex_h_sat;
                CFG_CEILING_COLOR: ceil_color_reg  <= cfg_data[COLOR_W-1:0];
                CFG_FLOOR_COLOR:   floor_color_reg <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Bound follows the registers in the next cycle; config is quiet by then.
    always_ff @(posedge aclk) begin
        bound_reg <= FULL_W'(pitch_reg * scr_h_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves while the skid is empty
    // ------------------------------------------------------------------
    logic      en;
    logic      skid_valid_reg;
    logic      m_valid_reg;
    out_beat_t out_reg;
    out_beat_t skid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: unpack, classify, products, row offset
    // ------------------------------------------------------------------
    s1_stage_t s1_next, s1_reg;

    logic [COL_W-1:0] in_col;
    logic [ROW_W-1:0] in_row;
    logic [ROW_W-1:0] in_start;
    logic [END_W-1:0] in_end;
    logic [LH_W-1:0]  in_lh;
    logic [TEX_W-1:0] in_tex;

    always_comb begin
        in_col   = s_tdata[10:0];
        in_row   = s_tdata[21:11];
        in_start = s_tdata[32:22];
        in_end   = s_tdata[44:33];
        in_lh    = s_tdata[60:45];
        in_tex   = s_tdata[70:61];

        s1_next.valid = s_tvalid;
        if (in_row < in_start)
            s1_next.region = REGION_CEILING;
        else if ({1'b0, in_row} < in_end)
            s1_next.region = REGION_WALL;
        else
            s1_next.region = REGION_FLOOR;
        s1_next.ok_fill  = {1'b0, in_row} < scr_h_reg;
        s1_next.row_prod = ROWP_W'(in_row * pitch_reg);
        s1_next.col_prod = COLP_W'(in_col * bpp_reg);
        // row - H/2 + lh/2, truncating halves
        s1_next.n0 = $signed({6'b0, in_row}) - $signed({6'b0, scr_h_reg[SCR_W-1:1]})
                   + $signed({2'b0, in_lh[LH_W-1:1]});
        s1_next.divisor = in_lh;
        s1_next.zflag   = (in_lh == '0) || (tex_h_reg == '0);
        s1_next.tex_col = in_tex;
    end

    // ------------------------------------------------------------------
    // Stage 2: full address sum, offset times texture height
    // ------------------------------------------------------------------
    s2_stage_t s2_next, s2_reg;

    always_comb begin
        s2_next.valid   = s1_reg.valid;
        s2_next.region  = s1_reg.region;
        s2_next.ok_fill = s1_reg.ok_fill;
        s2_next.addr    = FULL_W'(s1_reg.row_prod) + FULL_W'(s1_reg.col_prod);
        s2_next.nprod   = NPROD_W'(s1_reg.n0) * $signed({{(NPROD_W-TEXH_W){1'b0}}, tex_h_reg});
        s2_next.divisor = s1_reg.divisor;
        s2_next.zflag   = s1_reg.zflag;
        s2_next.tex_col = s1_reg.tex_col;
    end

    // ------------------------------------------------------------------
    // Stage 3: sign split and wall bound check, divider setup
    // ------------------------------------------------------------------
    div_stage_t div0_next;
    div_stage_t div_reg [0:DIV_STEPS];
    logic [NPROD_W-1:0] nprod_abs;

    always_comb begin
        nprod_abs = s2_reg.nprod[NPROD_W-1] ? NPROD_W'(-s2_reg.nprod)
                                             : NPROD_W'(s2_reg.nprod);
        div0_next.valid   = s2_reg.valid;
        div0_next.region  = s2_reg.region;
        div0_next.ok      = (s2_reg.region == REGION_WALL) ? (s2_reg.addr < bound_reg)
                                                           : s2_reg.ok_fill;
        div0_next.addr    = s2_reg.addr[ADDR_W-1:0];
        div0_next.neg     = s2_reg.nprod[NPROD_W-1];
        div0_next.zflag   = s2_reg.zflag;
        div0_next.tex_col = s2_reg.tex_col;
        div0_next.divisor = s2_reg.divisor;
        div0_next.rem     = '0;
        div0_next.dq      = nprod_abs[MAG_W-1:0];
    end

    // One restoring step: brings in the next dividend bit, emits one quotient bit.
    function automatic div_stage_t div_step(input div_stage_t st);
        div_stage_t        nx;
        logic [LH_W:0]     trial;
        logic [LH_W+1:0]   diff;
        nx    = st;
        trial = {st.rem, st.dq[MAG_W-1]};
        diff  = {1'b0, trial} - {2'b0, st.divisor};
        if (!diff[LH_W+1]) begin
            nx.rem = diff[LH_W-1:0];
            nx.dq  = {st.dq[MAG_W-2:0], 1'b1};
        end else begin
            nx.rem = trial[LH_W-1:0];
            nx.dq  = {st.dq[MAG_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                div_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            div_reg[0] <= div0_next;
            for (int k = 0; k < DIV_STEPS; k++) begin
                div_reg[k+1] <= div_step(div_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Fix-up: floor quotient for negative dividends, mask, fill select
    // ------------------------------------------------------------------
    div_stage_t        tail;
    out_beat_t         fin;
    logic [MAG_W-1:0]  q_floor;
    logic [TEXH_W-1:0] tex_mask;
    logic              push;

    always_comb begin
        tail = div_reg[DIV_STEPS];
        if (!tail.neg)
            q_floor = tail.dq;
        else if (tail.rem != '0)
            q_floor = ~tail.dq;            // -q - 1
        else
            q_floor = MAG_W'(-tail.dq);
        tex_mask = tex_h_reg - TEXH_W'(1);

        fin.region = tail.region;
        fin.addr   = tail.addr;
        fin.ok     = tail.ok;
        case (tail.region)
            REGION_CEILING: fin.fill = ceil_color_reg;
            REGION_FLOOR:   fin.fill = floor_color_reg;
            default:        fin.fill = '0;
        endcase
        if (tail.region == REGION_WALL) begin
            fin.texel_x = tail.tex_col;
            fin.texel_y = tail.zflag ? '0 : (q_floor[TEX_W-1:0] & tex_mask[TEX_W-1:0]);
        end else begin
            fin.texel_x = '0;
            fin.texel_y = '0;
        end
        push = tail.valid && en;
    end

    // ------------------------------------------------------------------
    // Output register with one-beat skid
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || m_tready) begin
                out_reg     <= fin;
                m_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= fin;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.region;
    assign m_tdata  = {2'b0, out_reg.texel_y, out_reg.texel_x, out_reg.fill,
                       out_reg.ok, out_reg.addr};

`ifndef NO_ASSERTIONS
    // A parked beat means the output register is holding one too.
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a beat while output is empty");

    // The skid only fills when the output was blocked.
    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid filled without a stalled output");

    // Non-wall results carry no texture coordinates.
    a_nonwall_texel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.region != REGION_WALL)
            |-> (out_reg.texel_x == '0 && out_reg.texel_y == '0))
        else $error("texel fields set on a ceiling or floor beat");

    // Wall results carry no fill color.
    a_wall_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.region == REGION_WALL) |-> (out_reg.fill == '0))
        else $error("fill color set on a wall beat");
`endif

endmodule

@@ bench/tb_raycast_column_pixel_shader.sv @@
// Self-checking bench for the raycast column pixel shader: directed and random beats, scoreboard predictor.
module tb_raycast_column_pixel_shader;
    import rcps_pkg::*;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int LONG_HOLD       = 300;     // receiver hold-off in cycles
    localparam int DRAIN_CYCLES    = 40;      // pipeline is 30 deep plus skid
    localparam int MAX_REPORTS     = 10;

    // Input beat, laid out exactly as s_tdata (first field in the low bits).
    typedef struct packed {
        logic              pad;
        logic [TEX_W-1:0]  texture_column;
        logic [LH_W-1:0]   wall_height;
        logic [END_W-1:0]  span_end;
        logic [ROW_W-1:0]  span_start;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
    } pixel_t;

    // Result beat, laid out as m_tdata; the region rides on m_tuser.
    typedef struct packed {
        logic [1:0]          pad;
        logic [TEX_W-1:0]    texel_y;
        logic [TEX_W-1:0]    texel_x;
        logic [COLOR_W-1:0]  fill_color;
        logic                write_ok;
        logic [ADDR_W-1:0]   byte_address;
    } shade_data_t;

    typedef struct {
        region_t     region;
        shade_data_t data;
    } shade_t;

    // Holds a private copy of the registers, predicts each accepted pixel and
    // checks result beats in order against the predicted ones.
    class shade_scoreboard;
        logic [PITCH_W-1:0] pitch;
        logic [BPP_W-1:0]   bpp;
        logic [SCR_W-1:0]   scr_h;
        logic [TEXH_W-1:0]  tex_h;
        logic [COLOR_W-1:0] ceil_rgb;
        logic [COLOR_W-1:0] floor_rgb;
        shade_t             shade_q[$];
        int                 failures;

        function new();
            pitch     = 15'd4096;
            bpp       = 4'd4;
            scr_h     = 12'd720;
            tex_h     = 11'd64;
            ceil_rgb  = '0;
            floor_rgb = '0;
            failures  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_ROW_PITCH:     pitch = v[PITCH_W-1:0];
                CFG_BYTES_PER_PIX: bpp = v[BPP_W-1:0];
                // screen and texture heights saturate rather than wrap
                CFG_SCREEN_HEIGHT: scr_h = (v[SCR_W-1:0] > MAX_SCREEN) ?
                                           SCR_W'(MAX_SCREEN) : v[SCR_W-1:0];
                CFG_TEX_HEIGHT:    tex_h = (v[TEXH_W-1:0] > MAX_TEXTURE) ?
                                           TEXH_W'(MAX_TEXTURE) : v[TEXH_W-1:0];
                CFG_CEILING_COLOR: ceil_rgb = v[COLOR_W-1:0];
                CFG_FLOOR_COLOR:   floor_rgb = v[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // floor((y - H/2 + lh/2) * texh / lh), masked by texh - 1
        function logic [TEX_W-1:0] texture_row(logic [ROW_W-1:0] y, logic [LH_W-1:0] lh);
            longint n, q, m;
            if (lh == 0 || tex_h == 0)
                return '0;
            n = longint'(y) - longint'(scr_h >> 1) + longint'(lh >> 1);
            n = n * longint'(tex_h);
            q = n / longint'(lh);
            // C-style division truncates; step down for negative remainders
            if ((n % longint'(lh)) != 0 && n < 0)
                q = q - 1;
            m = longint'(tex_h) - 1;
            return TEX_W'(q & m);
        endfunction

        function shade_t shade(pixel_t p);
            shade_t r;
            longint addr;
            addr = longint'(p.row) * longint'(pitch) + longint'(p.column) * longint'(bpp);
            r.data = '0;
            r.data.byte_address = addr[ADDR_W-1:0];
            if (p.row < p.span_start) begin
                r.region = REGION_CEILING;
                r.data.fill_color = ceil_rgb;
                r.data.write_ok = (p.row < scr_h);
            end else if (p.row < p.span_end) begin
                r.region = REGION_WALL;
                // bound uses the unclipped address
                r.data.write_ok = (addr < longint'(pitch) * longint'(scr_h));
                r.data.texel_x = p.texture_column;
                r.data.texel_y = texture_row(p.row, p.wall_height);
            end else begin
                r.region = REGION_FLOOR;
                r.data.fill_color = floor_rgb;
                r.data.write_ok = (p.row < scr_h);
            end
            return r;
        endfunction

        function void note_pixel(pixel_t p);
            shade_q.push_back(shade(p));
        endfunction

        function void check_beat(logic [M_USER_W-1:0] user, shade_data_t got);
            shade_t want;
            if (shade_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result beat: region %0d addr %h", user,
                             got.byte_address);
                return;
            end
            want = shade_q.pop_front();
            if (user != want.region ||
                got.byte_address != want.data.byte_address ||
                got.write_ok != want.data.write_ok ||
                got.fill_color != want.data.fill_color ||
                got.texel_x != want.data.texel_x ||
                got.texel_y != want.data.texel_y) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"mismatch (expected/actual): region %0d/%0d addr %h/%h ",
                              "ok %0d/%0d fill %h/%h tex_x %0d/%0d tex_y %0d/%0d"},
                             want.region, user,
                             want.data.byte_address, got.byte_address,
                             want.data.write_ok, got.write_ok,
                             want.data.fill_color, got.fill_color,
                             want.data.texel_x, got.texel_x,
                             want.data.texel_y, got.texel_y);
            end
        endfunction

        function int pending();
            return shade_q.size();
        endfunction
    endclass

    // DUT signals; every input has a known value from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    shade_scoreboard sb;
    bit  hold_req = 1'b0;    // asks the receiver for one long hold-off
    bit  gaps_on  = 1'b1;    // sender idles between bursts when set
    int  burst_left = 1;

    raycast_column_pixel_shader uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitors run on pre-edge values, so they see exactly what the DUT saw.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready)
                sb.note_pixel(pixel_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_beat(m_tuser, shade_data_t'(m_tdata));
        end
    end

    // Receiver back-pressure: segments of always-ready, coin-flip, periodic
    // and mostly-ready behavior, plus one long hold-off on request.
    initial begin : receiver
        int mode, seg, k, c;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 120);
            k    = $urandom_range(2, 6);
            for (c = 0; c < seg; c++) begin
                @(posedge aclk);
                if (hold_req) begin
                    // pipeline and skid fill up, then s_tready must drop
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ((c % k) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic pixel_t mk_pixel(int col, int row, int start, int stop,
                                        int lh, int tx);
        pixel_t p;
        p = '0;
        p.column         = COL_W'(col);
        p.row            = ROW_W'(row);
        p.span_start     = ROW_W'(start);
        p.span_end       = END_W'(stop);
        p.wall_height    = LH_W'(lh);
        p.texture_column = TEX_W'(tx);
        return p;
    endfunction

    // Mostly raycaster-shaped columns (wall centered on the horizon, row on
    // screen); one in five beats is raw noise across every field bit.
    function automatic pixel_t rand_pixel();
        int sh, lh, mid, start, stop;
        pixel_t p;
        sh = int'(sb.scr_h);
        if (sh < 1)
            sh = 1;
        if (sh > MAX_SCREEN)
            sh = MAX_SCREEN;
        if ($urandom_range(0, 4) == 0) begin
            p = pixel_t'({$urandom, $urandom, $urandom});
            p.pad = 1'b0;
            return p;
        end
        if ($urandom_range(0, 7) == 0)
            lh = $urandom_range(1, 65535);
        else
            lh = $urandom_range(1, 2 * sh);
        mid   = sh / 2;
        start = mid - lh / 2;
        stop  = mid + lh / 2;
        if (start < 0)
            start = 0;
        if (stop > sh)
            stop = sh;
        return mk_pixel($urandom_range(0, 2047), $urandom_range(0, sh - 1),
                        start, stop, lh, $urandom_range(0, 1023));
    endfunction

    // One input beat; called at a rising edge, returns at the accepting edge or after a burst gap.
    task automatic send_pixel(input pixel_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    task automatic cfg_beat(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] pitch, bpp, sh, texh,
                                  ceil_rgb, floor_rgb);
        cfg_beat(CFG_ROW_PITCH, pitch);
        cfg_beat(CFG_BYTES_PER_PIX, bpp);
        cfg_beat(CFG_SCREEN_HEIGHT, sh);
        cfg_beat(CFG_TEX_HEIGHT, texh);
        cfg_beat(CFG_CEILING_COLOR, ceil_rgb);
        cfg_beat(CFG_FLOOR_COLOR, floor_rgb);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, then wait until every predicted beat has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin : stimulus
        pixel_t directed[$];
        int phase, i;
        sb = new();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset settings (720 rows, 64 texture rows)
        directed.push_back(mk_pixel(0, 0, 0, 0, 0, 0));              // all zero: floor
        directed.push_back(mk_pixel(2047, 2047, 2047, 4095, 65535, 1023)); // field maxima
        directed.push_back(mk_pixel(10, 3, 10, 20, 7, 5));           // ceiling
        directed.push_back(mk_pixel(100, 360, 300, 420, 120, 1023)); // wall, mid texture
        directed.push_back(mk_pixel(100, 500, 100, 400, 300, 1));    // floor
        directed.push_back(mk_pixel(7, 200, 400, 100, 50, 9));       // inverted span: ceiling
        directed.push_back(mk_pixel(7, 50, 400, 100, 50, 9));        // inverted span: ceiling
        directed.push_back(mk_pixel(1, 5, 0, 10, 0, 3));             // wall, zero height
        directed.push_back(mk_pixel(2, 0, 0, 10, 100, 4));           // negative texture row
        directed.push_back(mk_pixel(3, 1, 0, 720, 1, 7));            // height one
        directed.push_back(mk_pixel(4, 719, 2047, 2047, 64, 0));     // last visible ceiling
        directed.push_back(mk_pixel(4, 720, 2047, 2047, 64, 0));     // ceiling below screen
        directed.push_back(mk_pixel(5, 719, 0, 0, 64, 0));           // last visible floor
        directed.push_back(mk_pixel(5, 720, 0, 0, 64, 0));           // floor below screen
        directed.push_back(mk_pixel(6, 300, 300, 400, 100, 2));      // first wall row
        directed.push_back(mk_pixel(6, 399, 300, 400, 100, 2));      // last wall row
        directed.push_back(mk_pixel(6, 400, 300, 400, 100, 2));      // row at span end
        directed.push_back(mk_pixel(1023, 719, 0, 2048, 65535, 512)); // wall, edge of bound
        directed.push_back(mk_pixel(0, 720, 0, 2048, 720, 512));     // wall past bound
        directed.push_back(mk_pixel(2047, 1000, 0, 4095, 3, 1023));  // short wall, far row
        foreach (directed[i])
            send_pixel(directed[i]);
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_settings(1, 1, 1, 1, 0, 0);                         // minima
                1: write_settings(16384, 8, 2048, 1024, 24'hFFFFFF, 24'hFFFFFF); // maxima
                // oversized: saturated heights, wrapping address
                2: write_settings(32767, 15, 4095, 2047, CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom));
                3: write_settings(0, 0, 0, 0, CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom));                    // zero pitch, size and heights
                4: write_settings(CFG_DATA_W'($urandom_range(1, 16384)),
                                  CFG_DATA_W'($urandom_range(1, 8)),
                                  CFG_DATA_W'($urandom_range(1, 2048)), 100,
                                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                default: write_settings(CFG_DATA_W'($urandom_range(1, 16384)),
                                        CFG_DATA_W'($urandom_range(1, 8)),
                                        CFG_DATA_W'($urandom_range(1, 2048)),
                                        CFG_DATA_W'(1 << $urandom_range(0, 10)),
                                        CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            endcase
            gaps_on = ((phase % 3) != 1);
            if (phase == 5) begin
                // steady offer against a long receiver hold-off
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_pixel(rand_pixel());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            $display("%0d expected result beats never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rcps_pkg.sv
rtl/raycast_column_pixel_shader.sv
bench/tb_raycast_column_pixel_shader.sv
